// File: hw/rtl/rci_pkg.sv
// Shared types and constants of the ray versus capped cylinder intersector.
`default_nettype none
package rci_pkg;

  localparam int SQ_LAT = 64;
  localparam int QBITS = 31;
  localparam int DIV_LAT = QBITS + 3;
  localparam int PIPE_DEPTH = 6 + SQ_LAT + 1 + DIV_LAT + 6;

  localparam logic [1:0] REG_Y_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MAX = 2'd1;
  localparam logic [1:0] REG_CAPS = 2'd2;

  localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] T_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [64:0] h;
    logic [63:0] a;
    logic a_small;
    logic disc_neg;
    logic cap_en;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [32:0] cn0;
    logic signed [32:0] cn1;
    logic [31:0] dym;
  } sq_side_t;

  typedef struct packed {
    logic a_small;
    logic disc_neg;
    logic cap_en;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } div_side_t;

  typedef struct packed {
    logic a_small;
    logic disc_neg;
    logic cap_en;
    logic wall_ok0;
    logic wall_ok1;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    logic signed [31:0] tc0;
    logic signed [31:0] tc1;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
  } post_t;

  typedef struct packed {
    logic [3:0] found;
    logic [3:0][31:0] t;
  } cand_t;

  typedef struct packed {
    logic signed [31:0] t;
    logic hit;
    logic cap;
  } ent_t;

endpackage
`default_nettype wire

// File: hw/rtl/ray_cylinder_intersect_unit.sv
// Top level of the ray versus capped cylinder intersector.
// Throughput: one ray per cycle; a ray with n hits yields n result words, a miss one word,
// and the whole pipeline stalls while its last stage holds a ray the buffer cannot take.
// The 64-stage root pipeline and the 34-stage dividers set the latency.
// Reset clears the stage valid bits, empties the result buffer, opens the caps and widens the height range.
`default_nettype none
module ray_cylinder_intersect_unit #(
  parameter int FRAC_BITS = 16,
  parameter int EPSILON_LSB = 7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] origin_z,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic signed [31:0] dir_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      hit_distance,
  output logic                    hit_valid,
  output logic                    hit_on_cap,
  output logic                    last_result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int LAST = rci_pkg::PIPE_DEPTH - 1;
  localparam logic [64:0] ONE2 = 65'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] A_EPS = 64'(EPSILON_LSB) << FRAC_BITS;
  localparam logic [127:0] LIM = (128'd1 << (4 * FRAC_BITS))
                               + (128'(EPSILON_LSB) << (3 * FRAC_BITS));

  logic signed [31:0] y_minimum;
  logic signed [31:0] y_maximum;
  logic               caps_closed;

  logic [LAST:0] vld;
  logic          en;
  logic          take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_minimum   <= rci_pkg::T_MIN;
      y_maximum   <= rci_pkg::T_MAX;
      caps_closed <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rci_pkg::REG_Y_MIN: y_minimum <= $signed(cfg_data);
        rci_pkg::REG_Y_MAX: y_maximum <= $signed(cfg_data);
        rci_pkg::REG_CAPS:  caps_closed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it halts only when its last stage cannot drain.
  assign en       = !vld[LAST] || take;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // Wall quadratic setup.
  logic signed [63:0] s1_dxdx, s1_dzdz, s1_oxdx, s1_ozdz, s1_oxox, s1_ozoz;
  rci_pkg::sq_side_t  s1_side, s2_side, s3_side, s4_side, s5_side, s6_side;
  rci_pkg::sq_side_t  s2_side_next, s6_side_next;
  logic signed [64:0] s2_c;
  logic [63:0]        s3_hm, s3_cm;
  logic               s3_cneg, s4_cneg, s5_cneg;
  logic [63:0]        s4_hh, s4_hl, s4_ll, s4_chh, s4_chl, s4_clh, s4_cll;
  logic [127:0]       s5_hm2, s5_ca;
  logic [127:0]       s6_disc;

  always_comb begin
    s2_side_next         = s1_side;
    s2_side_next.a       = 64'(s1_dxdx) + 64'(s1_dzdz);
    s2_side_next.a_small = s2_side_next.a < A_EPS;
    s2_side_next.h       = 65'(s1_oxdx) + 65'(s1_ozdz);
    s2_side_next.cap_en  = caps_closed && (s1_side.dym >= 32'(EPSILON_LSB));

    // A negative c adds to the discriminant.
    s6_side_next          = s5_side;
    s6_side_next.disc_neg = s5_cneg ? 1'b0 : (s5_hm2 < s5_ca);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dxdx <= dir_x * dir_x;
      s1_dzdz <= dir_z * dir_z;
      s1_oxdx <= origin_x * dir_x;
      s1_ozdz <= origin_z * dir_z;
      s1_oxox <= origin_x * origin_x;
      s1_ozoz <= origin_z * origin_z;
      s1_side.h        <= '0;
      s1_side.a        <= '0;
      s1_side.a_small  <= 1'b0;
      s1_side.disc_neg <= 1'b0;
      s1_side.cap_en   <= 1'b0;
      s1_side.ox  <= origin_x;
      s1_side.oy  <= origin_y;
      s1_side.oz  <= origin_z;
      s1_side.dx  <= dir_x;
      s1_side.dy  <= dir_y;
      s1_side.dz  <= dir_z;
      s1_side.cn0 <= 33'(y_minimum) - 33'(origin_y);
      s1_side.cn1 <= 33'(y_maximum) - 33'(origin_y);
      s1_side.dym <= dir_y[31] ? (~dir_y + 32'd1) : dir_y;

      s2_side <= s2_side_next;
      s2_c    <= $signed(65'(s1_oxox) + 65'(s1_ozoz) - ONE2);

      s3_side <= s2_side;
      s3_hm   <= s2_side.h[64] ? 64'(-s2_side.h) : s2_side.h[63:0];
      s3_cm   <= s2_c[64] ? 64'(-s2_c) : s2_c[63:0];
      s3_cneg <= s2_c[64];

      s4_side <= s3_side;
      s4_cneg <= s3_cneg;
      s4_hh   <= s3_hm[63:32] * s3_hm[63:32];
      s4_hl   <= s3_hm[63:32] * s3_hm[31:0];
      s4_ll   <= s3_hm[31:0] * s3_hm[31:0];
      s4_chh  <= s3_cm[63:32] * s3_side.a[63:32];
      s4_chl  <= s3_cm[63:32] * s3_side.a[31:0];
      s4_clh  <= s3_cm[31:0] * s3_side.a[63:32];
      s4_cll  <= s3_cm[31:0] * s3_side.a[31:0];

      s5_side <= s4_side;
      s5_cneg <= s4_cneg;
      s5_hm2  <= (128'(s4_hh) << 64) + (128'(s4_hl) << 33) + 128'(s4_ll);
      s5_ca   <= (128'(s4_chh) << 64) + (128'(s4_chl) << 32)
               + (128'(s4_clh) << 32) + 128'(s4_cll);

      s6_side <= s6_side_next;
      s6_disc <= s5_cneg ? s5_hm2 + s5_ca : s5_hm2 - s5_ca;
    end
  end

  // Root of the discriminant, with the ray data riding alongside.
  logic [63:0]       sq_root;
  rci_pkg::sq_side_t sq_side;
  logic [$bits(rci_pkg::sq_side_t)-1:0] sq_side_bits;

  rci_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (s6_disc),
    .root (sq_root)
  );

  rci_delay #(
    .W     ($bits(rci_pkg::sq_side_t)),
    .DEPTH (rci_pkg::SQ_LAT)
  ) u_sq_delay (
    .clk (clk),
    .en  (en),
    .d   (s6_side),
    .q   (sq_side_bits)
  );

  assign sq_side = sq_side_bits;

  logic signed [65:0] n1_sum0, n1_sum1;
  rci_pkg::sq_side_t  n1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_side <= sq_side;
      n1_sum0 <= -66'(sq_side.h) - $signed({2'b00, sq_root});
      n1_sum1 <= -66'(sq_side.h) + $signed({2'b00, sq_root});
    end
  end

  // Four divisions in step: two wall roots and the two cap planes.
  logic signed [31:0] d_t0, d_t1, d_tc0, d_tc1;
  rci_pkg::div_side_t n1_dside, d_side;
  logic [$bits(rci_pkg::div_side_t)-1:0] d_side_bits;

  rci_div_pipe #(.XW(66), .SHIFT(FRAC_BITS), .DW(64)) u_div_w0 (
    .clk (clk), .en (en), .num (n1_sum0), .flip (1'b0), .den (n1_side.a), .quot (d_t0)
  );

  rci_div_pipe #(.XW(66), .SHIFT(FRAC_BITS), .DW(64)) u_div_w1 (
    .clk (clk), .en (en), .num (n1_sum1), .flip (1'b0), .den (n1_side.a), .quot (d_t1)
  );

  rci_div_pipe #(.XW(33), .SHIFT(FRAC_BITS), .DW(32)) u_div_c0 (
    .clk (clk), .en (en), .num (n1_side.cn0), .flip (n1_side.dy[31]),
    .den (n1_side.dym), .quot (d_tc0)
  );

  rci_div_pipe #(.XW(33), .SHIFT(FRAC_BITS), .DW(32)) u_div_c1 (
    .clk (clk), .en (en), .num (n1_side.cn1), .flip (n1_side.dy[31]),
    .den (n1_side.dym), .quot (d_tc1)
  );

  always_comb begin
    n1_dside.a_small  = n1_side.a_small;
    n1_dside.disc_neg = n1_side.disc_neg;
    n1_dside.cap_en   = n1_side.cap_en;
    n1_dside.ox       = n1_side.ox;
    n1_dside.oy       = n1_side.oy;
    n1_dside.oz       = n1_side.oz;
    n1_dside.dx       = n1_side.dx;
    n1_dside.dy       = n1_side.dy;
    n1_dside.dz       = n1_side.dz;
  end

  rci_delay #(
    .W     ($bits(rci_pkg::div_side_t)),
    .DEPTH (rci_pkg::DIV_LAT)
  ) u_div_delay (
    .clk (clk),
    .en  (en),
    .d   (n1_dside),
    .q   (d_side_bits)
  );

  assign d_side = d_side_bits;

  // Height test of the wall hits and disc test of the cap hits.
  rci_pkg::post_t     p1_post, p2_post, p3_post, p4_post, p5_post, p6_post;
  rci_pkg::post_t     p2_post_next;
  logic signed [63:0] p1_ydy0, p1_ydy1, p1_xa, p1_za, p1_xb, p1_zb;
  logic signed [64:0] p2_xa, p2_za, p2_xb, p2_zb;
  logic [63:0]        p3_m [4];
  logic [63:0]        p4_hh [4];
  logic [63:0]        p4_hl [4];
  logic [63:0]        p4_ll [4];
  logic [127:0]       p5_sq [4];
  logic               p6_hit0, p6_hit1;

  logic signed [64:0] y0, y1, ymin_ext, ymax_ext;

  always_comb begin
    ymin_ext = 65'(y_minimum) <<< FRAC_BITS;
    ymax_ext = 65'(y_maximum) <<< FRAC_BITS;
    y0 = (65'(p1_post.oy) <<< FRAC_BITS) + 65'(p1_ydy0);
    y1 = (65'(p1_post.oy) <<< FRAC_BITS) + 65'(p1_ydy1);
    p2_post_next          = p1_post;
    p2_post_next.wall_ok0 = (ymin_ext < y0) && (y0 < ymax_ext);
    p2_post_next.wall_ok1 = (ymin_ext < y1) && (y1 < ymax_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_post.a_small  <= d_side.a_small;
      p1_post.disc_neg <= d_side.disc_neg;
      p1_post.cap_en   <= d_side.cap_en;
      p1_post.wall_ok0 <= 1'b0;
      p1_post.wall_ok1 <= 1'b0;
      p1_post.t0       <= d_t0;
      p1_post.t1       <= d_t1;
      p1_post.tc0      <= d_tc0;
      p1_post.tc1      <= d_tc1;
      p1_post.ox       <= d_side.ox;
      p1_post.oy       <= d_side.oy;
      p1_post.oz       <= d_side.oz;
      p1_ydy0 <= d_t0 * d_side.dy;
      p1_ydy1 <= d_t1 * d_side.dy;
      p1_xa   <= d_tc0 * d_side.dx;
      p1_za   <= d_tc0 * d_side.dz;
      p1_xb   <= d_tc1 * d_side.dx;
      p1_zb   <= d_tc1 * d_side.dz;

      p2_post <= p2_post_next;
      p2_xa <= (65'(p1_post.ox) <<< FRAC_BITS) + 65'(p1_xa);
      p2_za <= (65'(p1_post.oz) <<< FRAC_BITS) + 65'(p1_za);
      p2_xb <= (65'(p1_post.ox) <<< FRAC_BITS) + 65'(p1_xb);
      p2_zb <= (65'(p1_post.oz) <<< FRAC_BITS) + 65'(p1_zb);

      p3_post <= p2_post;
      p3_m[0] <= p2_xa[64] ? 64'(-p2_xa) : p2_xa[63:0];
      p3_m[1] <= p2_za[64] ? 64'(-p2_za) : p2_za[63:0];
      p3_m[2] <= p2_xb[64] ? 64'(-p2_xb) : p2_xb[63:0];
      p3_m[3] <= p2_zb[64] ? 64'(-p2_zb) : p2_zb[63:0];

      p4_post <= p3_post;
      for (int i = 0; i < 4; i++) begin
        p4_hh[i] <= p3_m[i][63:32] * p3_m[i][63:32];
        p4_hl[i] <= p3_m[i][63:32] * p3_m[i][31:0];
        p4_ll[i] <= p3_m[i][31:0] * p3_m[i][31:0];
      end

      p5_post <= p4_post;
      for (int i = 0; i < 4; i++) begin
        p5_sq[i] <= (128'(p4_hh[i]) << 64) + (128'(p4_hl[i]) << 33) + 128'(p4_ll[i]);
      end

      p6_post <= p5_post;
      p6_hit0 <= (p5_sq[0] + p5_sq[1]) < LIM;
      p6_hit1 <= (p5_sq[2] + p5_sq[3]) < LIM;
    end
  end

  // A negative discriminant on a tested wall kills every hit, caps included.
  rci_pkg::cand_t cand;
  logic           wall_on;
  logic           miss_all;

  always_comb begin
    wall_on       = !p6_post.a_small;
    miss_all      = wall_on && p6_post.disc_neg;
    cand.found[0] = wall_on && !p6_post.disc_neg && p6_post.wall_ok0;
    cand.found[1] = wall_on && !p6_post.disc_neg && p6_post.wall_ok1;
    cand.found[2] = !miss_all && p6_post.cap_en && p6_hit0;
    cand.found[3] = !miss_all && p6_post.cap_en && p6_hit1;
    cand.t        = {p6_post.tc1, p6_post.tc0, p6_post.t1, p6_post.t0};
  end

  rci_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (vld[LAST]),
    .cand         (cand),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit_distance (hit_distance),
    .hit_valid    (hit_valid),
    .hit_on_cap   (hit_on_cap),
    .last_result  (last_result)
  );

  // A ray's run of hits is never cut short.
  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |=> out_valid)
    else $error("result run ended before its last word");

  // With the result buffer empty the pipeline never stalls its input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result buffer empty");

  // A miss word stands alone and carries no cap mark.
  a_miss_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_valid |-> last_result && !hit_on_cap)
    else $error("miss word not alone");

endmodule
`default_nettype wire

// File: hw/rtl/rci_delay.sv
// Enabled delay line that carries side data alongside a long pipeline unit.
`default_nettype none
module rci_delay #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule
`default_nettype wire

// File: hw/rtl/rci_sqrt_pipe.sv
// Pipelined integer square root of a 128-bit word, one root bit per stage.
`default_nettype none
module rci_sqrt_pipe (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [127:0] v,
  output logic      [63:0]  root
);

  localparam int N = rci_pkg::SQ_LAT;

  logic [65:0]  rem_q  [N];
  logic [63:0]  root_q [N];
  logic [127:0] v_q    [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [65:0]  ri;
    logic [63:0]  rti;
    logic [127:0] vi;
    logic [67:0]  r2;
    logic [67:0]  trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign ri  = '0;
      assign rti = '0;
      assign vi  = v;
    end else begin : g_next
      assign ri  = rem_q[k-1];
      assign rti = root_q[k-1];
      assign vi  = v_q[k-1];
    end

    // Bring down the next two bits and try 4*root+1.
    assign r2    = {ri, vi[127:126]};
    assign trial = {2'b00, rti, 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? 66'(r2 - trial) : r2[65:0];
        root_q[k] <= {rti[62:0], ge};
        v_q[k]    <= {vi[125:0], 2'b00};
      end
    end
  end

  assign root = root_q[N-1];

endmodule
`default_nettype wire

// File: hw/rtl/rci_div_pipe.sv
// Pipelined restoring divider with truncation toward zero and 32-bit saturation.
`default_nettype none
module rci_div_pipe #(
  parameter int XW = 33,
  parameter int SHIFT = 16,
  parameter int DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [XW-1:0] num,
  input  wire logic                 flip,
  input  wire logic        [DW-1:0] den,
  output logic signed      [31:0]   quot
);

  localparam int QB = rci_pkg::QBITS;
  localparam int MW = XW + SHIFT;
  localparam int RW = ((MW > DW + QB) ? MW : DW + QB) + 1;

  logic [XW-1:0] num_mag;
  logic [MW-1:0] a_mag;
  logic          a_neg;
  logic [DW-1:0] a_den;

  logic [RW-1:0] st_rem [QB+1];
  logic [QB-1:0] st_q   [QB+1];
  logic [DW-1:0] st_den [QB+1];
  logic          st_neg [QB+1];
  logic          st_sat [QB+1];

  assign num_mag = num[XW-1] ? XW'(-num) : XW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= MW'(num_mag) << SHIFT;
      a_neg <= num[XW-1] ^ flip;
      a_den <= den;
      // A quotient of 2^31 or more saturates.
      st_sat[0] <= RW'(a_mag) >= (RW'(a_den) << QB);
      st_rem[0] <= RW'(a_mag);
      st_q[0]   <= '0;
      st_den[0] <= a_den;
      st_neg[0] <= a_neg;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(st_den[i-1]) << (QB - i);
    assign ge    = st_rem[i-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i] <= ge ? st_rem[i-1] - trial : st_rem[i-1];
        st_q[i]   <= st_q[i-1] | (ge ? (QB'(1) << (QB - i)) : '0);
        st_den[i] <= st_den[i-1];
        st_neg[i] <= st_neg[i-1];
        st_sat[i] <= st_sat[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st_sat[QB]) begin
        quot <= st_neg[QB] ? rci_pkg::T_MIN : rci_pkg::T_MAX;
      end else if (st_neg[QB]) begin
        quot <= -$signed({1'b0, st_q[QB]});
      end else begin
        quot <= $signed({1'b0, st_q[QB]});
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rci_emit.sv
// Result buffer that packs the hits of one ray and hands them out one word at a time.
`default_nettype none
module rci_emit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load_valid,
  input  wire rci_pkg::cand_t        cand,
  output logic                       take,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [31:0]         hit_distance,
  output logic                       hit_valid,
  output logic                       hit_on_cap,
  output logic                       last_result
);

  logic [2:0]     cnt;
  rci_pkg::ent_t  slot [4];
  rci_pkg::ent_t  packed_ent [4];
  logic [2:0]     n_found;
  logic           load;
  logic           emit;

  // Squeeze the found hits to the front, keeping their order.
  always_comb begin
    rci_pkg::ent_t e;
    e = '0;
    for (int i = 0; i < 4; i++) begin
      packed_ent[i] = '0;
    end
    n_found = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand.found[i]) begin
        e.t = $signed(cand.t[i]);
        e.hit = 1'b1;
        e.cap = (i >= 2);
        packed_ent[n_found[1:0]] = e;
        n_found = n_found + 3'd1;
      end
    end
    if (n_found == 3'd0) begin
      n_found = 3'd1;
    end
  end

  assign take = (cnt == 3'd0) || (cnt == 3'd1 && !out_stall);
  assign load = load_valid && take;
  assign emit = (cnt != 3'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= n_found;
    end else if (emit) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        slot[i] <= packed_ent[i];
      end
    end else if (emit) begin
      for (int i = 0; i < 3; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign out_valid    = cnt != 3'd0;
  assign hit_distance = slot[0].t;
  assign hit_valid    = slot[0].hit;
  assign hit_on_cap   = slot[0].cap;
  assign last_result  = cnt == 3'd1;

endmodule
`default_nettype wire
